// File: sv/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types and constants for the 1bpp BMP stream decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

  localparam int unsigned DimBits = 16;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_MAGIC  = 3'd1;
  localparam logic [2:0] ERR_HSIZE  = 3'd2;
  localparam logic [2:0] ERR_COMPR  = 3'd3;
  localparam logic [2:0] ERR_BPP    = 3'd4;
  localparam logic [2:0] ERR_TRUNC  = 3'd5;
  localparam logic [2:0] ERR_SIZE   = 3'd6;

  // One queued transaction from the parser to the emitter.
  typedef struct packed {
    logic                 hdr;      // emit header result
    logic                 err;      // emit error result after pixels
    logic [2:0]           code;
    logic [3:0]           npix;     // pixels to emit, 0..8
    logic [7:0]           bits;
    logic [DimBits-1:0]   col0;
    logic [DimBits-1:0]   row;
    logic                 pal;
    logic [23:0]          c0;
    logic [23:0]          c1;
    logic [DimBits-1:0]   width;
    logic [DimBits-1:0]   height;
    logic                 top_down;
  } job_t;

endpackage

// File: sv/bmp_1bpp_stream_decoder.sv
// ----------------------------------------------------------------------------
// bmp_1bpp_stream_decoder
// 1bpp BMP byte stream to header, pixel and error results.
//
// channel  direction  handshake          payload
// in       input      valid_i/stall_o    file_byte_i, end_of_file_i
// out      output     valid_o/stall_i    kind_o .. last_o
//
// A byte with results is loaded into the emitter as one job, which gives up to
// nine results (eight pixels and an error).
// The parser takes one byte per cycle while the job register is free.
// Reset clears all control state; no clearing pass.
// Output stalls back up through the emitter into the parser.
// ----------------------------------------------------------------------------
module bmp_1bpp_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  file_byte_i,
  input  logic        end_of_file_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [15:0] pixel_column_o,
  output logic [15:0] pixel_row_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic        top_down_o,
  output logic [2:0]  error_code_o,
  output logic        last_o
);

  bmpd_pkg::job_t job;
  logic           job_valid, job_stall;

  bmpd_parse u_parse (
    .clk_i, .rst_ni, .valid_i, .stall_o, .file_byte_i, .end_of_file_i,
    .job_valid_o(job_valid), .job_stall_i(job_stall), .job_o(job)
  );

  bmpd_emit u_emit (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_stall_o(job_stall), .job_i(job),
    .valid_o, .stall_i, .kind_o, .red_o, .green_o, .blue_o, .pixel_column_o,
    .pixel_row_o, .image_width_o, .image_height_o, .top_down_o, .error_code_o, .last_o
  );

endmodule

// File: sv/bmpd_parse.sv
// ----------------------------------------------------------------------------
// bmpd_parse
// Header, palette and row bookkeeping; produces one job per input byte with results.
// ----------------------------------------------------------------------------
module bmpd_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [7:0]         file_byte_i,
  input  logic               end_of_file_i,
  output logic               job_valid_o,
  input  logic               job_stall_i,
  output bmpd_pkg::job_t     job_o
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_PALETTE = 3'd1;
  localparam logic [2:0] PH_DATA    = 3'd2;
  localparam logic [2:0] PH_DONE    = 3'd3;
  localparam logic [2:0] PH_ERROR   = 3'd4;
  localparam int unsigned DB = bmpd_pkg::DimBits;

  logic [2:0]  phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] acc_q;
  logic [31:0] fsz_q, off_q, w_q, h_q, comp_q, isz_q;
  logic [15:0] bpp_q;
  logic [7:0]  pal_q [8];
  logic        palp_q, palp_d;
  logic [DB-1:0] row_q, row_d;
  logic [13:0] rbc_q, rbc_d;
  logic [DB-1:0] habs_q;
  logic [13:0] stride_q;
  logic        hdr_ok_q;

  logic        take;
  logic [31:0] acc_n;
  logic [31:0] habs;
  logic [31:0] idx;
  bmpd_pkg::job_t job_d;
  logic        emit_d;
  logic [DB+3:0] col0_w, remain;

  assign stall_o = job_valid_o && job_stall_i;
  assign take    = valid_i && !stall_o;
  assign acc_n   = {file_byte_i, acc_q[31:8]};
  assign habs    = h_q[31] ? (32'd0 - h_q) : h_q;
  assign idx     = pos_q - 32'd54;
  assign col0_w  = {3'b000, rbc_q, 3'b000};
  assign remain  = {4'd0, w_q[DB-1:0]} - col0_w;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    palp_d  = palp_q;
    row_d   = row_q;
    rbc_d   = rbc_q;
    emit_d  = 1'b0;
    job_d   = '0;
    job_d.bits = file_byte_i;
    job_d.col0 = col0_w[DB-1:0];
    job_d.row  = row_q;
    job_d.pal  = palp_q;
    job_d.c0   = {pal_q[2], pal_q[1], pal_q[0]};
    job_d.c1   = {pal_q[6], pal_q[5], pal_q[4]};
    job_d.width    = w_q[DB-1:0];
    job_d.height   = habs_q;
    job_d.top_down = h_q[31];
    unique case (phase_q)
      PH_HEADER: begin
        pos_d = pos_q + 32'd1;
        if (pos_q == 32'd1) begin
          if (!(acc_n[31:16] == 16'h4D42 || acc_n[31:16] == 16'h4D41 ||
                acc_n[31:16] == 16'h4943 || acc_n[31:16] == 16'h5043 ||
                acc_n[31:16] == 16'h5450)) begin
            job_d.err = 1'b1; job_d.code = bmpd_pkg::ERR_MAGIC;
            phase_d = PH_ERROR;
          end
        end else if (pos_q == 32'd17) begin
          if (acc_n != 32'd40) begin
            job_d.err = 1'b1; job_d.code = bmpd_pkg::ERR_HSIZE;
            phase_d = PH_ERROR;
          end
        end else if (pos_q == 32'd53) begin
          if (comp_q > 32'd3) begin
            job_d.err = 1'b1; job_d.code = bmpd_pkg::ERR_COMPR; phase_d = PH_ERROR;
          end else if (bpp_q != 16'd1) begin
            job_d.err = 1'b1; job_d.code = bmpd_pkg::ERR_BPP; phase_d = PH_ERROR;
          end else if (!hdr_ok_q) begin
            job_d.err = 1'b1; job_d.code = bmpd_pkg::ERR_SIZE; phase_d = PH_ERROR;
          end else begin
            job_d.hdr = 1'b1;
            if (off_q > 32'd54) begin
              palp_d = 1'b1; phase_d = PH_PALETTE;
            end else if (w_q == 32'd0 || habs_q == '0) begin
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
      end
      PH_PALETTE: begin
        pos_d = pos_q + 32'd1;
        if (pos_d >= off_q)
          phase_d = (w_q == 32'd0 || habs_q == '0) ? PH_DONE : PH_DATA;
      end
      PH_DATA: begin
        job_d.npix = ({4'd0, w_q[DB-1:0]} <= col0_w) ? 4'd0 :
                     ((remain >= (DB+4)'(8)) ? 4'd8 : remain[3:0]);
        rbc_d = rbc_q + 14'd1;
        if (rbc_d >= stride_q) begin
          rbc_d = '0;
          row_d = row_q + DB'(1);
          if (row_d >= habs_q) phase_d = PH_DONE;
        end
      end
      PH_DONE, PH_ERROR: ;
      default: ;
    endcase
    if (end_of_file_i && (phase_d == PH_HEADER || phase_d == PH_PALETTE ||
                          phase_d == PH_DATA)) begin
      job_d.err  = 1'b1;
      job_d.code = bmpd_pkg::ERR_TRUNC;
    end
    emit_d = job_d.hdr || job_d.err || (job_d.npix != 4'd0);
    if (end_of_file_i) begin
      phase_d = PH_HEADER; pos_d = '0; palp_d = 1'b0; row_d = '0; rbc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q <= '0; acc_q <= '0; palp_q <= 1'b0; row_q <= '0; rbc_q <= '0;
      fsz_q <= '0; off_q <= '0; w_q <= '0; h_q <= '0; comp_q <= '0; isz_q <= '0;
      bpp_q <= '0; habs_q <= '0; stride_q <= '0; hdr_ok_q <= 1'b0;
      job_valid_o <= 1'b0;
    end else begin
      if (take && emit_d) job_valid_o <= 1'b1;
      else if (!job_stall_i) job_valid_o <= 1'b0;
      if (take) begin
        phase_q <= phase_d; pos_q <= pos_d; palp_q <= palp_d;
        row_q <= row_d; rbc_q <= rbc_d;
        acc_q <= end_of_file_i ? '0 : acc_n;
        if (end_of_file_i) begin
          fsz_q <= '0; off_q <= '0; w_q <= '0; h_q <= '0; comp_q <= '0;
          isz_q <= '0; bpp_q <= '0; habs_q <= '0; stride_q <= '0; hdr_ok_q <= 1'b0;
        end else if (phase_q == PH_HEADER) begin
          if (pos_q == 32'd5)  fsz_q <= acc_n;
          if (pos_q == 32'd13) off_q <= acc_n;
          if (pos_q == 32'd21) begin
            w_q <= acc_n;
            stride_q <= 14'((({1'b0, acc_n[DB-1:0]} + (DB+1)'(31)) >> 5) << 2);
          end
          if (pos_q == 32'd25) h_q <= acc_n;
          if (pos_q == 32'd29) bpp_q <= acc_n[31:16];
          if (pos_q == 32'd33) comp_q <= acc_n;
          if (pos_q == 32'd37) isz_q <= acc_n;
          if (pos_q == 32'd38) habs_q <= habs[DB-1:0];
          if (pos_q == 32'd39)
            hdr_ok_q <= (w_q[31:DB] == '0) && (habs[31:DB] == '0);
          if (pos_q == 32'd40)
            hdr_ok_q <= hdr_ok_q && (comp_q == 32'd0 || isz_q == fsz_q - off_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && phase_q == PH_PALETTE && idx < 32'd8) pal_q[idx[2:0]] <= file_byte_i;
    if (take && emit_d) job_o <= job_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o && job_stall_i |=> job_valid_o)
    else $error("job dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> job_o.npix <= 4'd8)
    else $error("pixel count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_ERROR)
    else $error("bad phase");

endmodule

// File: sv/bmpd_emit.sv
// ----------------------------------------------------------------------------
// bmpd_emit
// Expands queued jobs into header, pixel and error results, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module bmpd_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_stall_o,
  input  bmpd_pkg::job_t     job_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [15:0]        pixel_column_o,
  output logic [15:0]        pixel_row_o,
  output logic [15:0]        image_width_o,
  output logic [15:0]        image_height_o,
  output logic               top_down_o,
  output logic [2:0]         error_code_o,
  output logic               last_o
);

  bmpd_pkg::job_t cur_q;
  logic           busy_q;
  logic [3:0]     k_q, k_d;
  logic           hdone_q, hdone_d;
  logic           free, more;
  logic [1:0]     kind_d;
  logic [23:0]    rgb;
  logic           bit_v;
  logic [2:0]     code_d;

  assign free        = !valid_o || !stall_i;
  assign job_stall_o = busy_q || !free;

  always_comb begin
    k_d = k_q; hdone_d = hdone_q; code_d = bmpd_pkg::ERR_NONE;
    kind_d = bmpd_pkg::KIND_PIXEL;
    bit_v = cur_q.bits[3'd7 - k_q[2:0]];
    rgb = cur_q.pal ? (bit_v ? cur_q.c1 : cur_q.c0) : {24{bit_v}};
    if (cur_q.hdr && !hdone_q) begin
      kind_d = bmpd_pkg::KIND_HEADER; hdone_d = 1'b1;
    end else if (k_q < cur_q.npix) begin
      k_d = k_q + 4'd1;
    end else begin
      kind_d = bmpd_pkg::KIND_ERROR; code_d = cur_q.code; k_d = 4'd9;
    end
    more = (k_d < cur_q.npix) || (cur_q.err && k_d != 4'd9);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; valid_o <= 1'b0; k_q <= '0; hdone_q <= 1'b0;
    end else if (free) begin
      valid_o <= busy_q;
      if (busy_q) begin
        k_q <= k_d; hdone_q <= hdone_d;
        if (!more) busy_q <= 1'b0;
      end else if (job_valid_i) begin
        busy_q <= 1'b1; k_q <= '0; hdone_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free && !busy_q && job_valid_i) cur_q <= job_i;
    if (free && busy_q) begin
      kind_o <= kind_d;
      error_code_o <= code_d;
      last_o <= !more;
      if (kind_d == bmpd_pkg::KIND_PIXEL) begin
        {red_o, green_o, blue_o} <= rgb;
        pixel_column_o <= 16'(cur_q.col0 + 16'(k_q));
        pixel_row_o <= cur_q.row;
      end else begin
        {red_o, green_o, blue_o} <= '0; pixel_column_o <= '0; pixel_row_o <= '0;
      end
      image_width_o  <= (kind_d == bmpd_pkg::KIND_HEADER) ? cur_q.width : '0;
      image_height_o <= (kind_d == bmpd_pkg::KIND_HEADER) ? cur_q.height : '0;
      top_down_o     <= (kind_d == bmpd_pkg::KIND_HEADER) && cur_q.top_down;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o == bmpd_pkg::KIND_ERROR |-> last_o)
    else $error("error result not last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> k_q <= 4'd8)
    else $error("pixel index overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o != bmpd_pkg::KIND_ERROR |-> error_code_o == bmpd_pkg::ERR_NONE)
    else $error("stray error code");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 1bpp BMP stream decoder. BMP files are built in
// the bench: valid, corrupted, truncated, palette and no-palette. They are fed
// one byte per transaction with random gaps, and the output side is stalled
// at random and once for a long stretch. A local decoder model predicts every
// header, pixel and error result, and a checker compares each one in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3000000;
  localparam logic [15:0] MAGIC_BM = 16'h4D42;
  localparam logic [15:0] MAGIC_BA = 16'h4D41;
  localparam logic [15:0] MAGIC_CI = 16'h4943;
  localparam logic [15:0] MAGIC_CP = 16'h5043;
  localparam logic [15:0] MAGIC_PT = 16'h5450;
  localparam logic [31:0] InfoSize = 32'd40;
  localparam logic [31:0] HdrBytes = 32'd54;
  localparam logic [31:0] DimMax   = 32'd65535;

  typedef enum logic [2:0] {
    ST_HEADER, ST_PALETTE, ST_DATA, ST_DONE, ST_ERROR
  } parse_state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] col;
    logic [15:0] row;
    logic [15:0] width;
    logic [15:0] height;
    logic        top_down;
    logic [2:0]  code;
    logic        last;
  } bmp_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [7:0]  file_byte_i = 8'd0;
  logic        end_of_file_i = 1'b0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  red_o, green_o, blue_o;
  logic [15:0] pixel_column_o, pixel_row_o, image_width_o, image_height_o;
  logic        top_down_o;
  logic [2:0]  error_code_o;
  logic        last_o;

  bmp_1bpp_stream_decoder dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // decoder model state
  parse_state_e st;
  logic [31:0]  pos, acc, f_size, f_off, h_size, f_w, f_h, f_bpp, f_compr, f_isize;
  logic [7:0]   pal [8];
  logic         pal_on;
  logic [31:0]  row_cnt, row_bytes;

  bmp_result_t  pend_q[$];
  bmp_result_t  expected_q[$];
  logic [7:0]   file_q[$];

  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  results_seen = 0;
  int unsigned  files_sent = 0;
  int unsigned  hold_req = 0;
  int unsigned  stall_left = 0;

  function automatic logic [31:0] abs_h();
    return f_h[31] ? (32'd0 - f_h) : f_h;
  endfunction

  function automatic void emit(logic [1:0] k, logic [7:0] r, logic [7:0] g,
                               logic [7:0] b, logic [15:0] c, logic [15:0] rw,
                               logic [15:0] w, logic [15:0] h, logic td,
                               logic [2:0] code);
    bmp_result_t e;
    e = '{k, r, g, b, c, rw, w, h, td, code, 1'b0};
    pend_q.push_back(e);
  endfunction

  function automatic void decoder_clear();
    st = ST_HEADER;
    pos = 0; acc = 0; f_size = 0; f_off = 0; h_size = 0; f_w = 0; f_h = 0;
    f_bpp = 0; f_compr = 0; f_isize = 0; pal_on = 0; row_cnt = 0; row_bytes = 0;
    foreach (pal[i]) pal[i] = 8'd0;
  endfunction

  function automatic void fail_with(logic [2:0] code);
    st = ST_ERROR;
    emit(bmpd_pkg::KIND_ERROR, '0, '0, '0, '0, '0, '0, '0, 1'b0, code);
  endfunction

  function automatic void enter_data();
    st = (f_w == 0 || abs_h() == 0) ? ST_DONE : ST_DATA;
  endfunction

  function automatic void finish_header();
    logic [31:0] ah;
    ah = abs_h();
    if (f_compr > 3) fail_with(bmpd_pkg::ERR_COMPR);
    else if (f_bpp != 1) fail_with(bmpd_pkg::ERR_BPP);
    else if (f_compr != 0 && f_isize != f_size - f_off) fail_with(bmpd_pkg::ERR_SIZE);
    else if (f_w > DimMax || ah > DimMax) fail_with(bmpd_pkg::ERR_SIZE);
    else begin
      emit(bmpd_pkg::KIND_HEADER, '0, '0, '0, '0, '0, f_w[15:0], ah[15:0], f_h[31],
           bmpd_pkg::ERR_NONE);
      if (f_off > HdrBytes) begin
        pal_on = 1'b1;
        st = ST_PALETTE;
      end else begin
        enter_data();
      end
    end
  endfunction

  function automatic void expand_byte(logic [7:0] b);
    logic [63:0] stride, c;
    logic        bit_v;
    logic [7:0]  r, g, bl;
    stride = ((64'(f_w) + 31) >> 5) << 2;
    for (int k = 0; k < 8; k++) begin
      c = 64'(row_bytes) * 8 + k;
      if (c < 64'(f_w)) begin
        bit_v = b[7-k];
        if (pal_on) begin
          r = pal[bit_v*4+2]; g = pal[bit_v*4+1]; bl = pal[bit_v*4];
        end else begin
          r = {8{bit_v}}; g = r; bl = r;
        end
        emit(bmpd_pkg::KIND_PIXEL, r, g, bl, c[15:0], row_cnt[15:0], '0, '0, 1'b0,
             bmpd_pkg::ERR_NONE);
      end
    end
    row_bytes++;
    if (64'(row_bytes) >= stride) begin
      row_bytes = 0;
      row_cnt++;
      if (row_cnt >= abs_h()) st = ST_DONE;
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic eof);
    logic [31:0] p;
    pend_q.delete();
    case (st)
      ST_HEADER: begin
        p = pos;
        acc = {b, acc[31:8]};
        pos++;
        case (p)
          1: if (!(acc[31:16] inside {MAGIC_BM, MAGIC_BA, MAGIC_CI, MAGIC_CP, MAGIC_PT}))
               fail_with(bmpd_pkg::ERR_MAGIC);
          5:  f_size = acc;
          13: f_off = acc;
          17: begin
            h_size = acc;
            if (acc != InfoSize) fail_with(bmpd_pkg::ERR_HSIZE);
          end
          21: f_w = acc;
          25: f_h = acc;
          29: f_bpp = {16'd0, acc[31:16]};
          33: f_compr = acc;
          37: f_isize = acc;
          53: finish_header();
          default: ;
        endcase
      end
      ST_PALETTE: begin
        if (pos - HdrBytes < 8) pal[pos-HdrBytes] = b;
        pos++;
        if (pos >= f_off) enter_data();
      end
      ST_DATA: expand_byte(b);
      default: ;
    endcase
    if (eof) begin
      if (st inside {ST_HEADER, ST_PALETTE, ST_DATA}) fail_with(bmpd_pkg::ERR_TRUNC);
      decoder_clear();
    end
    if (pend_q.size() > 0) pend_q[$].last = 1'b1;
    foreach (pend_q[i]) expected_q.push_back(pend_q[i]);
  endfunction

  // one input transaction, sometimes followed by a random gap
  task automatic send_byte(logic [7:0] b, logic eof);
    int unsigned r;
    valid_i <= 1'b1;
    file_byte_i <= b;
    end_of_file_i <= eof;
    do @(posedge clk_i); while (stall_o);
    predict_byte(b, eof);
    bytes_sent++;
    r = $urandom_range(0, 99);
    if (r >= 60) begin
      valid_i <= 1'b0;
      repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(8, 40)) @(posedge clk_i);
    end
  endtask

  task automatic send_file(int unsigned n);
    for (int i = 0; i < n && i < file_q.size(); i++)
      send_byte(file_q[i], i == n - 1 || i == file_q.size() - 1);
    files_sent++;
  endtask

  function automatic void put32(int at, logic [31:0] v);
    for (int i = 0; i < 4; i++) file_q[at+i] = v[8*i +: 8];
  endfunction

  function automatic void build_bmp(int w, int h, int pal_len, logic [15:0] magic,
                                    logic [31:0] compr, int extra);
    int unsigned ah, stride, off, data_len;
    ah = h < 0 ? -h : h;
    stride = ((w + 31) / 32) * 4;
    off = 54 + pal_len;
    data_len = stride * ah;
    file_q.delete();
    for (int i = 0; i < off + data_len + extra; i++)
      file_q.push_back(8'($urandom_range(0, 255)));
    file_q[0] = magic[7:0];
    file_q[1] = magic[15:8];
    put32(2, off + data_len);
    put32(6, 0);
    put32(10, off);
    put32(14, InfoSize);
    put32(18, w);
    put32(22, h);
    file_q[26] = 8'd1; file_q[27] = 8'd0;
    file_q[28] = 8'd1; file_q[29] = 8'd0;
    put32(30, compr);
    put32(34, data_len);
  endfunction

  task automatic test_magic_values();
    logic [15:0] m [4] = '{MAGIC_BA, MAGIC_CI, MAGIC_CP, MAGIC_PT};
    build_bmp(1, 1, 0, MAGIC_BM, 0, 0);
    send_file(file_q.size());
    foreach (m[i]) begin
      build_bmp(1, 1, 0, m[i], 0, 0);
      send_file(2);
    end
    build_bmp(1, 1, 0, 16'h4D4D, 0, 0);
    send_file(2);
  endtask

  task automatic test_header_checks();
    build_bmp(8, 1, 0, MAGIC_BM, 0, 0); file_q[14] = 8'd41;
    send_file(18);
    build_bmp(8, 1, 0, MAGIC_BM, 2, 0); put32(34, 32'd5);
    send_file(54);
  endtask

  task automatic test_output_hold();
    build_bmp(33, -2, 8, MAGIC_CI, 1, 0);
    hold_req = 600;
    send_file(file_q.size());
  endtask

  task automatic test_truncation();
    build_bmp(16, 2, 8, MAGIC_BM, 0, 0);
    send_file(11);
  endtask

  // output side: random stalls, plus a long hold on request
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end else if (stall_left == 0) begin
      case ($urandom_range(0, 39))
        0:       stall_left = $urandom_range(10, 30);
        1, 2, 3,
        4, 5, 6: stall_left = $urandom_range(1, 3);
        default: stall_left = 0;
      endcase
      if ($urandom_range(0, 3) == 0) stall_left = 0;
    end
    stall_i <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk_i) begin
    bmp_result_t got, exp_r;
    if (rst_ni && valid_o && !stall_i) begin
      got = '{kind_o, red_o, green_o, blue_o, pixel_column_o, pixel_row_o,
              image_width_o, image_height_o, top_down_o, error_code_o, last_o};
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %p", $time, got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          errors++;
          $display("%0t: result mismatch, expected %p, actual %p", $time, exp_r, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    decoder_clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_magic_values();
    test_header_checks();
    test_output_hold();
    test_truncation();
    valid_i <= 1'b0;
    end_of_file_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("Fed %0d files (%0d bytes) and checked %0d results.",
             files_sent, bytes_sent, results_seen);
    $display("Covered header checks, palettes, truncation and output backpressure.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
